// ----- design/tls_pkg.sv -----
package tls_pkg;

	// Command queue sizing; depth must be a power of two
	localparam int CMD_DEPTH = 4;
	localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
	localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

	// Token kinds
	localparam logic [3:0] KIND_END    = 4'd0;
	localparam logic [3:0] KIND_NL     = 4'd1;
	localparam logic [3:0] KIND_EMPTY  = 4'd2;
	localparam logic [3:0] KIND_LBRACE = 4'd3;
	localparam logic [3:0] KIND_RBRACE = 4'd4;
	localparam logic [3:0] KIND_LT     = 4'd5;
	localparam logic [3:0] KIND_GT     = 4'd6;
	localparam logic [3:0] KIND_LPAREN = 4'd7;
	localparam logic [3:0] KIND_RPAREN = 4'd8;
	localparam logic [3:0] KIND_LBRACK = 4'd9;
	localparam logic [3:0] KIND_RBRACK = 4'd10;
	localparam logic [3:0] KIND_COLON  = 4'd11;
	localparam logic [3:0] KIND_EQUAL  = 4'd12;
	localparam logic [3:0] KIND_NUM    = 4'd13;
	localparam logic [3:0] KIND_KEY    = 4'd14;
	localparam logic [3:0] KIND_UNK    = 4'd15;

	// Special characters
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_EMPTY = 8'h01;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_UNDER = 8'h5F;

	// Number of results in the expansion of a negated keyword
	localparam logic [2:0] NOT_LEN = 3'd5;

	// Body operation of one command
	typedef enum logic [1:0] {
		OP_NONE = 2'd0,
		OP_ONE  = 2'd1,
		OP_NOT  = 2'd2
	} op_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       restart;
	} item_t;

	typedef struct packed {
		logic [3:0] token_kind;
		logic [7:0] token_char;
		logic       char_valid;
		logic       token_start;
		logic       token_end;
		logic       last;
	} result_t;

	// One decoded input: optional close of the open token, then a body
	typedef struct packed {
		logic       close_en;
		logic [3:0] close_kind;
		op_t        op;
		logic [3:0] body_kind;
		logic [7:0] body_char;
		logic       body_valid;
		logic       body_start;
		logic       body_end;
	} cmd_t;

	// Text of the negated keyword, one byte per step
	function automatic logic [7:0] not_char(input logic [2:0] idx);
		logic [7:0] ch;
		unique case (idx)
			3'd0:    ch = 8'h4E;
			3'd1:    ch = 8'h4F;
			3'd2:    ch = 8'h54;
			default: ch = CH_UNDER;
		endcase
		return ch;
	endfunction

endpackage

// ----- design/tls_front.sv -----
module tls_front import tls_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  logic  full,
	input  item_t item,
	output logic  cmd_wr,
	output cmd_t  cmd
);

	typedef enum logic [3:0] {
		MODE_STOP = 4'b0001,
		MODE_IDLE = 4'b0010,
		MODE_NUM  = 4'b0100,
		MODE_KEY  = 4'b1000
	} mode_t;

	mode_t      mode_q;
	mode_t      mode_mid;
	mode_t      mode_d;
	logic       accept;
	logic       lex_en;
	logic [7:0] b;
	logic       is_digit;
	logic       is_letter;
	logic [4:0] mark;

	// Map a punctuation byte to its kind; top bit flags a hit
	function automatic logic [4:0] mark_kind(input logic [7:0] ch);
		logic [4:0] r;
		unique case (ch)
			8'h7B:   r = {1'b1, KIND_LBRACE};
			8'h7D:   r = {1'b1, KIND_RBRACE};
			8'h3C:   r = {1'b1, KIND_LT};
			8'h3E:   r = {1'b1, KIND_GT};
			8'h28:   r = {1'b1, KIND_LPAREN};
			8'h29:   r = {1'b1, KIND_RPAREN};
			8'h5B:   r = {1'b1, KIND_LBRACK};
			8'h5D:   r = {1'b1, KIND_RBRACK};
			8'h3A:   r = {1'b1, KIND_COLON};
			8'h3D:   r = {1'b1, KIND_EQUAL};
			default: r = {1'b0, KIND_END};
		endcase
		return r;
	endfunction

	assign accept    = push && !full;
	assign b         = item.text_byte;
	assign is_digit  = (b >= 8'h30) && (b <= 8'h39);
	assign is_letter = ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
	assign mark      = mark_kind(b);

	// Classify the byte against the scan mode
	always_comb begin
		cmd            = '0;
		cmd.close_kind = KIND_NUM;
		cmd.op         = OP_NONE;
		lex_en         = 1'b0;
		mode_mid       = mode_q;

		// restart closes any open token and begins a fresh text
		if (item.restart) begin
			mode_mid = MODE_IDLE;
			if (mode_q == MODE_NUM) begin
				cmd.close_en   = 1'b1;
				cmd.close_kind = KIND_NUM;
			end else if (mode_q == MODE_KEY) begin
				cmd.close_en   = 1'b1;
				cmd.close_kind = KIND_KEY;
			end
		end
		mode_d = mode_mid;

		unique case (mode_mid)
			MODE_STOP: begin
				lex_en = 1'b0;
			end
			MODE_IDLE: begin
				lex_en = 1'b1;
			end
			MODE_NUM: begin
				if (is_digit || b == CH_SLASH) begin
					cmd.op         = OP_ONE;
					cmd.body_kind  = KIND_NUM;
					cmd.body_char  = b;
					cmd.body_valid = 1'b1;
				end else begin
					cmd.close_en   = 1'b1;
					cmd.close_kind = KIND_NUM;
					lex_en         = 1'b1;
				end
			end
			MODE_KEY: begin
				if (is_letter || b == CH_UNDER) begin
					cmd.op         = OP_ONE;
					cmd.body_kind  = KIND_KEY;
					cmd.body_char  = b;
					cmd.body_valid = 1'b1;
				end else begin
					cmd.close_en   = 1'b1;
					cmd.close_kind = KIND_KEY;
					lex_en         = 1'b1;
				end
			end
			default: begin
				lex_en = 1'b0;
			end
		endcase

		// Lex the byte as the start of a token
		if (lex_en) begin
			mode_d         = MODE_IDLE;
			cmd.body_start = 1'b1;
			cmd.body_end   = 1'b1;
			cmd.op         = OP_ONE;
			priority if (b == CH_NUL) begin
				cmd.body_kind = KIND_END;
				mode_d        = MODE_STOP;
			end else if (b == CH_NL) begin
				cmd.body_kind = KIND_NL;
			end else if (b == CH_EMPTY) begin
				cmd.body_kind = KIND_EMPTY;
			end else if (b <= CH_SPACE) begin
				cmd.op = OP_NONE;
			end else if (mark[4]) begin
				cmd.body_kind = mark[3:0];
			end else if (is_digit || b == CH_MINUS) begin
				cmd.body_kind  = KIND_NUM;
				cmd.body_char  = b;
				cmd.body_valid = 1'b1;
				cmd.body_end   = 1'b0;
				mode_d         = MODE_NUM;
			end else if (is_letter || b == CH_UNDER) begin
				cmd.body_kind  = KIND_KEY;
				cmd.body_char  = b;
				cmd.body_valid = 1'b1;
				cmd.body_end   = 1'b0;
				mode_d         = MODE_KEY;
			end else if (b == CH_BANG) begin
				cmd.op        = OP_NOT;
				cmd.body_kind = KIND_KEY;
				cmd.body_end  = 1'b0;
				mode_d        = MODE_KEY;
			end else begin
				cmd.body_kind = KIND_UNK;
			end
		end
	end

	// Queue only inputs that produce results
	assign cmd_wr = accept && (cmd.close_en || cmd.op != OP_NONE);

	// Advance the scan mode on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_STOP;
		end else if (accept) begin
			mode_q <= mode_d;
		end
	end

endmodule

// ----- design/tls_cmd_fifo.sv -----
module tls_cmd_fifo import tls_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  cmd_t wdata,
	input  logic rd,
	output cmd_t rdata,
	output logic valid,
	output logic full
);

	cmd_t                 entry_q [CMD_DEPTH];
	logic [CMD_PTR_W-1:0] wr_ptr_q;
	logic [CMD_PTR_W-1:0] rd_ptr_q;
	logic [CMD_CNT_W-1:0] count_q;

	assign valid = count_q != '0;
	assign full  = count_q == CMD_CNT_W'(CMD_DEPTH);
	assign rdata = entry_q[rd_ptr_q];

	// Hold queued commands
	always_ff @(posedge clk) begin
		if (wr) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + CMD_PTR_W'(1);
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + CMD_PTR_W'(1);
			end
			if (wr && !rd) begin
				count_q <= count_q + CMD_CNT_W'(1);
			end else if (rd && !wr) begin
				count_q <= count_q - CMD_CNT_W'(1);
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr |-> (!full || rd))
		else $error("command written into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd |-> valid)
		else $error("command read from an empty queue");
`endif

endmodule

// ----- design/tls_back.sv -----
module tls_back import tls_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cmd_valid,
	input  cmd_t    cmd,
	output logic    cmd_pop,
	input  logic    pop,
	output logic    empty,
	output result_t result
);

	logic [2:0] idx_q;
	logic       out_valid_q;
	result_t    res_q;
	result_t    res_d;
	logic [2:0] n_close;
	logic [2:0] n_body;
	logic [2:0] total;
	logic [2:0] j;
	logic       at_last;
	logic       load;

	// Size the expansion of the current command
	always_comb begin
		n_close = {2'b00, cmd.close_en};
		unique case (cmd.op)
			OP_ONE:  n_body = 3'd1;
			OP_NOT:  n_body = NOT_LEN;
			default: n_body = 3'd0;
		endcase
		total   = n_close + n_body;
		j       = idx_q - n_close;
		at_last = idx_q == (total - 3'd1);
	end

	// Build the result at the current step
	always_comb begin
		res_d = '0;
		if (cmd.close_en && idx_q == 3'd0) begin
			res_d.token_kind = cmd.close_kind;
			res_d.token_end  = 1'b1;
		end else if (cmd.op == OP_ONE) begin
			res_d.token_kind  = cmd.body_kind;
			res_d.token_char  = cmd.body_char;
			res_d.char_valid  = cmd.body_valid;
			res_d.token_start = cmd.body_start;
			res_d.token_end   = cmd.body_end;
		end else begin
			res_d.token_kind  = KIND_KEY;
			res_d.token_char  = not_char(j);
			res_d.char_valid  = 1'b1;
			res_d.token_start = j == 3'd0;
		end
		res_d.last = at_last;
	end

	assign load    = cmd_valid && (!out_valid_q || pop);
	assign cmd_pop = load && at_last;
	assign empty   = !out_valid_q;
	assign result  = res_q;

	// Hold the result until it is transferred
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_d;
		end
	end

	// Step through the command and track the output slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q       <= at_last ? 3'd0 : idx_q + 3'd1;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= 3'd5)
		else $error("expansion step beyond six results");
	a_cmd_held: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q != 3'd0) |-> cmd_valid)
		else $error("command left the queue before its expansion ended");
	a_end_no_char: assert property (@(posedge clk) disable iff (!arst_n)
		(load && res_d.token_end) |-> !res_d.char_valid)
		else $error("token end result carries a text byte");
`endif

endmodule

// ----- design/token_lexer_stream_unit.sv -----
// Byte-serial lexer. One text byte is taken per cycle whenever full is low;
// the front end classifies it against the scan mode in the same cycle and
// writes a decoded command into a four-entry queue. The back end expands each
// command into one to six token results, one result per cycle into the output
// register while that register is free or being popped; '!' expands into the
// five-byte NOT__ keyword, plus a close result if a token was open. Sustained
// input rate is one byte per cycle as long as results are popped and the
// average expansion stays at one result per byte; the queue absorbs bursts
// of longer expansions before full rises. Each result passes through the
// queue and the output register.
module token_lexer_stream_unit import tls_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	output logic    full,
	input  item_t   item,
	output logic    empty,
	input  logic    pop,
	output result_t result
);

	logic cmd_wr;
	cmd_t cmd_in;
	cmd_t cmd_out;
	logic cmd_valid;
	logic cmd_pop;

	tls_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.cmd_wr (cmd_wr),
		.cmd    (cmd_in)
	);

	tls_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cmd_wr),
		.wdata  (cmd_in),
		.rd     (cmd_pop),
		.rdata  (cmd_out),
		.valid  (cmd_valid),
		.full   (full)
	);

	tls_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule
